/* hw/rtl/scmdc_pkg.sv */
// Shared types and constants for the skinned cloth max distance constraint block.
`timescale 1ns / 1ps
package scmdc_pkg;

   localparam int MAX_BONES   = 64;
   localparam int INFL        = 4;
   localparam int ROWS        = 3;
   localparam int ROW_WORDS   = 4;
   localparam int MAT_WORDS   = ROWS * ROW_WORDS;
   localparam int TABLE_WORDS = MAX_BONES * MAT_WORDS;
   localparam int BONE_W      = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int ID_W        = 6;
   localparam int WT_W        = 16;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_DISTANCE_SCALE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PIN_THRESHOLD  = 1'd1;

   localparam logic [15:0] DSCALE_RESET = 16'd256;
   localparam logic [16:0] PTHR_RESET   = 17'd655;

   typedef enum logic [1:0] {
      ST_FREE    = 2'd0,
      ST_PINNED  = 2'd1,
      ST_CLAMPED = 2'd2
   } scmdc_status_type;

   typedef struct packed {
      logic               mode;
      logic [9:0]         table_address;
      logic signed [31:0] table_value;
      logic signed [31:0] rest_x;
      logic signed [31:0] rest_y;
      logic signed [31:0] rest_z;
      logic signed [31:0] node_x;
      logic signed [31:0] node_y;
      logic signed [31:0] node_z;
      logic [23:0]        bone_ids;
      logic [63:0]        bone_weights;
      logic [16:0]        max_distance;
   } scmdc_req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [1:0]         status;
   } scmdc_rsp_type;

   typedef struct packed {
      logic [2:0][31:0] node;
      logic [2:0][31:0] key;
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      logic [63:0]      wts;
      logic [16:0]      md;
      logic             pin;
      logic             clamp;
      logic [31:0]      lim;
   } scmdc_carry_type;

endpackage

/* hw/rtl/skinned_cloth_max_distance_constraint.sv */
// Top level: bone table, four-bone skinning and max distance clamp pipeline.
//
// Input items arrive on req_valid/req_stall/req_data. A mode 0 item writes one
// word of the bone table (four read copies, one per influence) and gives no
// result. A mode 1 item skins one vertex and gives one result on
// rsp_valid/rsp_stall/rsp_data, in input order.
// Registers distance_scale and pin_threshold are written through csr_wr_en,
// csr_index and csr_wdata; the user must write them only while the block is
// idle, which the block itself does not enforce. Throughput: one item per
// cycle while rsp_stall is low; square root (two bits per stage, 16 stages)
// and divider (two quotient bits per stage, 12 stages) are fully pipelined.
// Each stage advances when it is empty or the stage after it advances, so a
// stalled result holds while empty stages upstream keep filling; req_stall
// rises only when every stage holds an item.
// Synchronous reset clears all valid bits and loads the register defaults;
// the bone table is undefined until written.
`timescale 1ns / 1ps
module skinned_cloth_max_distance_constraint (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  scmdc_pkg::scmdc_req_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output scmdc_pkg::scmdc_rsp_type             rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [scmdc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [scmdc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int NST    = 38;
   localparam int S_MUL  = 1;
   localparam int S_T    = 2;
   localparam int S_W    = 3;
   localparam int S_KEY  = 4;
   localparam int S_D    = 5;
   localparam int S_SQ   = 6;
   localparam int S_CMP  = 7;
   localparam int RT_ST  = 16;
   localparam int S_NUM  = S_CMP + RT_ST + 1;
   localparam int DV_ST  = 12;
   localparam int S_OUT  = S_NUM + DV_ST + 1;
   localparam int QW     = 2 * DV_ST;
   localparam int INFL   = scmdc_pkg::INFL;
   localparam int ROWS   = scmdc_pkg::ROWS;
   localparam int MW     = scmdc_pkg::MAT_WORDS;
   localparam int BONE_W = scmdc_pkg::BONE_W;

   localparam logic [11:0] RECIP12  = 12'd2731;
   localparam logic [11:0] TBL_LIM  = 12'(scmdc_pkg::TABLE_WORDS);
   localparam logic [8:0]  BONE_LIM = 9'(scmdc_pkg::MAX_BONES);
   localparam logic signed [65:0] S32MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32MIN = -66'sd2147483648;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > S32MAX) begin
         return S32MAX[31:0];
      end else if (v < S32MIN) begin
         return S32MIN[31:0];
      end
      return v[31:0];
   endfunction

   // handshake and configuration
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] adv;
   logic           req_acc;
   logic [15:0]    dscale_ff;
   logic [16:0]    pthr_ff;

   // bone table
   logic [31:0]       bank_mem [INFL][MW][scmdc_pkg::MAX_BONES];
   logic [21:0]       wr_prod;
   logic [6:0]        wr_bone;
   logic [9:0]        wr_rem;
   logic [3:0]        wr_elem;
   logic [BONE_W-1:0] wr_idx;
   logic              wr_en;

   // stage data
   logic [31:0]        mat_ff   [INFL][MW];
   logic [INFL-1:0]    bok_ff;
   logic [2:0][31:0]   rest_ff;
   logic signed [47:0] prod_in  [INFL][ROWS][3];
   logic signed [47:0] prod_ff  [INFL][ROWS][3];
   logic signed [31:0] trans_in [INFL][ROWS];
   logic signed [31:0] trans_ff [INFL][ROWS];
   logic signed [31:0] t_in     [INFL][ROWS];
   logic signed [31:0] t_ff     [INFL][ROWS];
   logic signed [48:0] wt_in    [INFL][ROWS];
   logic signed [48:0] wt_ff    [INFL][ROWS];
   logic [63:0]        sqp_in   [3];
   logic [63:0]        sqp_ff   [3];
   logic [63:0]        lim2_in;
   logic [63:0]        lim2_ff;
   logic [63:0]        rt_n_in  [RT_ST+1];
   logic [63:0]        rt_n_ff  [RT_ST+1];
   logic [63:0]        rt_r_in  [RT_ST+1];
   logic [63:0]        rt_r_ff  [RT_ST+1];
   logic [39:0]        den_in   [DV_ST+1];
   logic [39:0]        den_ff   [DV_ST+1];
   logic [63:0]        rem_in   [DV_ST+1][3];
   logic [63:0]        rem_ff   [DV_ST+1][3];
   logic [QW-1:0]      quo_in   [DV_ST+1][3];
   logic [QW-1:0]      quo_ff   [DV_ST+1][3];
   scmdc_pkg::scmdc_carry_type carry_in [S_OUT];
   scmdc_pkg::scmdc_carry_type carry_ff [S_OUT];
   scmdc_pkg::scmdc_rsp_type   rsp_in;
   scmdc_pkg::scmdc_rsp_type   rsp_ff;

   always_comb begin
      adv[NST-1] = !vld_ff[NST-1] || !rsp_stall;
      for (int i = NST - 2; i >= 0; i--) begin
         adv[i] = !vld_ff[i] || adv[i+1];
      end
   end

   assign req_stall = !adv[0];
   assign req_acc   = req_valid && adv[0];
   assign rsp_valid = vld_ff[NST-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         dscale_ff <= scmdc_pkg::DSCALE_RESET;
         pthr_ff   <= scmdc_pkg::PTHR_RESET;
      end else begin
         if (adv[0]) begin
            vld_ff[0] <= req_acc && req_data.mode;
         end
         for (int i = 1; i < NST; i++) begin
            if (adv[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               scmdc_pkg::CSR_DISTANCE_SCALE: dscale_ff <= csr_wdata[15:0];
               scmdc_pkg::CSR_PIN_THRESHOLD:  pthr_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // address / 12 by reciprocal multiply, exact for 10-bit addresses
   assign wr_prod = 22'(req_data.table_address) * 22'(RECIP12);
   assign wr_bone = wr_prod[21:15];
   assign wr_rem  = req_data.table_address - 10'({3'd0, wr_bone} * 10'd12);
   assign wr_elem = wr_rem[3:0];
   assign wr_idx  = BONE_W'(wr_bone);
   assign wr_en   = req_acc && !req_data.mode && ({2'd0, req_data.table_address} < TBL_LIM);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         for (int k = 0; k < INFL; k++) begin
            bank_mem[k][wr_elem][wr_idx] <= req_data.table_value;
         end
      end
      if (adv[0]) begin
         for (int k = 0; k < INFL; k++) begin
            for (int e = 0; e < MW; e++) begin
               mat_ff[k][e] <=
                  bank_mem[k][e][BONE_W'(req_data.bone_ids[k*scmdc_pkg::ID_W +: scmdc_pkg::ID_W])];
            end
            bok_ff[k] <= {3'd0, req_data.bone_ids[k*scmdc_pkg::ID_W +: scmdc_pkg::ID_W]} < BONE_LIM;
         end
         rest_ff <= {req_data.rest_z, req_data.rest_y, req_data.rest_x};
      end
   end

   always_comb begin
      logic signed [63:0] pr;
      logic signed [49:0] ts;
      logic signed [50:0] acc;
      logic signed [32:0] d;
      logic [16:0]        mds;
      logic [65:0]        s;
      logic [63:0]        n;
      logic [63:0]        r;
      logic [63:0]        bt;
      logic [63:0]        trial;
      logic [31:0]        sq_root;
      logic signed [32:0] sum;

      carry_in[0]      = '0;
      carry_in[0].node = {req_data.node_z, req_data.node_y, req_data.node_x};
      carry_in[0].wts  = req_data.bone_weights;
      carry_in[0].md   = req_data.max_distance;
      for (int i = 1; i < S_OUT; i++) begin
         carry_in[i] = carry_ff[i-1];
      end

      // stage 1: matrix times rest position, limit radius
      for (int k = 0; k < INFL; k++) begin
         for (int rw = 0; rw < ROWS; rw++) begin
            for (int c = 0; c < 3; c++) begin
               pr = $signed(bok_ff[k] ? mat_ff[k][rw*4+c] : 32'd0) * $signed(rest_ff[c]);
               prod_in[k][rw][c] = pr[63:16];
            end
            trans_in[k][rw] = $signed(bok_ff[k] ? mat_ff[k][rw*4+3] : 32'd0);
         end
      end
      mds = carry_ff[0].md[16] ? 17'h10000 : carry_ff[0].md;
      carry_in[S_MUL].pin = carry_ff[0].md <= pthr_ff;
      carry_in[S_MUL].lim = {15'd0, mds} * {16'd0, dscale_ff};

      // stage 2: per bone transformed row
      for (int k = 0; k < INFL; k++) begin
         for (int rw = 0; rw < ROWS; rw++) begin
            ts = 50'(prod_ff[k][rw][0]) + 50'(prod_ff[k][rw][1]) + 50'(prod_ff[k][rw][2])
               + 50'(trans_ff[k][rw]);
            t_in[k][rw] = sat32(66'(ts));
         end
      end

      // stage 3: weighting
      for (int k = 0; k < INFL; k++) begin
         for (int rw = 0; rw < ROWS; rw++) begin
            wt_in[k][rw] = $signed({1'b0, carry_ff[S_T].wts[k*scmdc_pkg::WT_W +: scmdc_pkg::WT_W]})
                         * t_ff[k][rw];
         end
      end

      // stage 4: blend to key position
      for (int rw = 0; rw < ROWS; rw++) begin
         acc = 51'(wt_ff[0][rw]) + 51'(wt_ff[1][rw]) + 51'(wt_ff[2][rw]) + 51'(wt_ff[3][rw]);
         carry_in[S_KEY].key[rw] = sat32(66'(acc >>> 15));
      end

      // stage 5: offset from key
      for (int c = 0; c < 3; c++) begin
         d = 33'($signed(carry_ff[S_KEY].node[c])) - 33'($signed(carry_ff[S_KEY].key[c]));
         carry_in[S_D].neg[c] = d[32];
         carry_in[S_D].mag[c] = d[32] ? 32'(-d) : d[31:0];
      end

      // stage 6: squares
      for (int c = 0; c < 3; c++) begin
         sqp_in[c] = 64'(carry_ff[S_D].mag[c]) * 64'(carry_ff[S_D].mag[c]);
      end
      lim2_in = 64'(carry_ff[S_D].lim) * 64'(carry_ff[S_D].lim);

      // stage 7: saturated squared length and clamp test
      s = 66'(sqp_ff[0]) + 66'(sqp_ff[1]) + 66'(sqp_ff[2]);
      rt_n_in[0] = (s[65:64] != 2'd0) ? '1 : s[63:0];
      rt_r_in[0] = '0;
      carry_in[S_CMP].clamp = !carry_ff[S_SQ].pin && (rt_n_in[0] > (lim2_ff >> 16));

      // integer square root, two result bits per stage
      for (int j = 0; j < RT_ST; j++) begin
         n = rt_n_ff[j];
         r = rt_r_ff[j];
         for (int m = 0; m < 2; m++) begin
            bt = 64'd1 << (62 - 2 * (2 * j + m));
            if (n >= r + bt) begin
               n = n - (r + bt);
               r = (r >> 1) + bt;
            end else begin
               r = r >> 1;
            end
         end
         rt_n_in[j+1] = n;
         rt_r_in[j+1] = r;
      end

      // numerator and divisor
      sq_root = (rt_r_ff[RT_ST] == 64'd0) ? 32'd1 : rt_r_ff[RT_ST][31:0];
      den_in[0] = {sq_root, 8'd0};
      for (int c = 0; c < 3; c++) begin
         rem_in[0][c] = 64'(carry_ff[S_NUM-1].mag[c]) * 64'(carry_ff[S_NUM-1].lim);
         quo_in[0][c] = '0;
      end

      // restoring division, two quotient bits per stage
      for (int j = 0; j < DV_ST; j++) begin
         den_in[j+1] = den_ff[j];
         for (int c = 0; c < 3; c++) begin
            n = rem_ff[j][c];
            quo_in[j+1][c] = quo_ff[j][c];
            for (int m = 0; m < 2; m++) begin
               trial = 64'(den_ff[j]) << (QW - 1 - 2 * j - m);
               if (n >= trial) begin
                  n = n - trial;
                  quo_in[j+1][c][QW-1-2*j-m] = 1'b1;
               end
            end
            rem_in[j+1][c] = n;
         end
      end

      // output select
      rsp_in = '0;
      for (int c = 0; c < 3; c++) begin
         sum = carry_ff[S_OUT-1].neg[c]
             ? 33'($signed(carry_ff[S_OUT-1].key[c])) - 33'(quo_ff[DV_ST][c])
             : 33'($signed(carry_ff[S_OUT-1].key[c])) + 33'(quo_ff[DV_ST][c]);
         if (carry_ff[S_OUT-1].pin) begin
            pr[31:0] = carry_ff[S_OUT-1].key[c];
         end else if (carry_ff[S_OUT-1].clamp) begin
            pr[31:0] = sat32(66'(sum));
         end else begin
            pr[31:0] = carry_ff[S_OUT-1].node[c];
         end
         pr[63:32] = '0;
         case (c)
            0:       rsp_in.out_x = pr[31:0];
            1:       rsp_in.out_y = pr[31:0];
            default: rsp_in.out_z = pr[31:0];
         endcase
      end
      if (carry_ff[S_OUT-1].pin) begin
         rsp_in.status = scmdc_pkg::ST_PINNED;
      end else if (carry_ff[S_OUT-1].clamp) begin
         rsp_in.status = scmdc_pkg::ST_CLAMPED;
      end else begin
         rsp_in.status = scmdc_pkg::ST_FREE;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < S_OUT; i++) begin
         if (adv[i]) begin
            carry_ff[i] <= carry_in[i];
         end
      end
      if (adv[S_MUL]) begin
         prod_ff  <= prod_in;
         trans_ff <= trans_in;
      end
      if (adv[S_T]) begin
         t_ff <= t_in;
      end
      if (adv[S_W]) begin
         wt_ff <= wt_in;
      end
      if (adv[S_SQ]) begin
         sqp_ff  <= sqp_in;
         lim2_ff <= lim2_in;
      end
      for (int j = 0; j <= RT_ST; j++) begin
         if (adv[S_CMP+j]) begin
            rt_n_ff[j] <= rt_n_in[j];
            rt_r_ff[j] <= rt_r_in[j];
         end
      end
      for (int j = 0; j <= DV_ST; j++) begin
         if (adv[S_NUM+j]) begin
            den_ff[j] <= den_in[j];
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
      if (adv[S_OUT]) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
